// File: design/mqss_pkg.sv
// Package for the multi-queue shared slot store.
// Holds the sizing constants, command and status codes, and the sequencer state type.
// Has no dependencies.
package mqss_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int NUM_QUEUES = 4;

  localparam int SLOT_W  = $clog2(NUM_SLOTS + 1);
  localparam int IDX_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int QIDX_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int QID_W   = 2;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;

  localparam int IN_DATA_W  = ((QID_W + VALUE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VALUE_W + STAT_W + 7) / 8) * 8;

  localparam logic [SLOT_W-1:0] NONE_PTR = SLOT_W'(NUM_SLOTS);

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } mqss_state_e;

endpackage

// File: design/multi_queue_shared_store.sv
// Multi-queue shared slot store: an item is registered on accept and executed in the execute state,
// so a new beat is taken only after the last one has executed; its result beat is registered.
// Each item does a read, then a modify and write back, of the link and data memories, which sets the accept rate.
// A held result stalls the execute step, and so the input, until it is taken.
// Reset empties every queue and puts all slots on the free list at once; it needs no sweep.
// Depends on mqss_pkg.
module multi_queue_shared_store (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0: queue_id[1:0], value[33:2], zero padding.
  input  logic [mqss_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // Fields from bit 0: cmd.
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Fields from bit 0: read_value[31:0], status[33:32], zero padding.
  output logic [mqss_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import mqss_pkg::*;

  mqss_state_e state_q, state_d;

  logic [SLOT_W-1:0]  head_q [NUM_QUEUES];
  logic [SLOT_W-1:0]  tail_q [NUM_QUEUES];
  logic [SLOT_W-1:0]  free_head_q;

  logic [SLOT_W-1:0]  link_mem [NUM_SLOTS];
  logic [VALUE_W-1:0] data_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] link_vld_q;
  logic [SLOT_W-1:0]  link_rd_q;
  logic [VALUE_W-1:0] data_rd_q;

  logic               cmd_q;
  logic [QIDX_W-1:0]  qidx_q;
  logic [VALUE_W-1:0] val_q;
  logic               err_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [SLOT_W-1:0]  tl_q;

  logic               out_vld_q;
  logic [VALUE_W-1:0] out_rv_q;
  logic [STAT_W-1:0]  out_st_q;

  logic               in_fire;
  logic               exec_fire;
  logic               in_cmd;
  logic [QID_W-1:0]   in_qid;
  logic [QIDX_W-1:0]  in_qidx;
  logic               in_q_ok;
  logic [SLOT_W-1:0]  in_head;
  logic [SLOT_W-1:0]  rd_ptr;
  logic               in_err;

  logic [SLOT_W-1:0]  link_val;
  logic [SLOT_W-1:0]  new_head;
  logic               link_we;
  logic [IDX_W-1:0]   link_waddr;
  logic [SLOT_W-1:0]  link_wdata;
  logic               enq_ok;
  logic               deq_ok;

  assign in_cmd  = s_axis_tuser;
  assign in_qid  = s_axis_tdata[QID_W-1:0];
  assign in_qidx = QIDX_W'(in_qid);
  assign in_q_ok = (32'(in_qid) < NUM_QUEUES);
  assign in_head = head_q[in_qidx];
  assign rd_ptr  = (in_cmd == CMD_DEQ) ? in_head : free_head_q;
  assign in_err  = !in_q_ok || (rd_ptr == NONE_PTR);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    exec_fire     = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_EXEC: exec_fire = !out_vld_q || m_axis_tready;
      default: begin
        s_axis_tready = 1'b0;
        exec_fire     = 1'b0;
      end
    endcase
  end

  // A link entry never written reads as the next slot number, since its link_vld_q bit is clear.
  assign link_val = link_vld_q[slot_q[IDX_W-1:0]] ? link_rd_q : (slot_q + SLOT_W'(1));
  assign new_head = (slot_q == tl_q) ? NONE_PTR : link_val;
  assign enq_ok   = exec_fire && (cmd_q == CMD_ENQ) && !err_q;
  assign deq_ok   = exec_fire && (cmd_q == CMD_DEQ) && !err_q;

  always_comb begin
    link_we    = 1'b0;
    link_waddr = slot_q[IDX_W-1:0];
    link_wdata = free_head_q;
    if (deq_ok) begin
      link_we = 1'b1;
    end else if (enq_ok && (tl_q != NONE_PTR)) begin
      link_we    = 1'b1;
      link_waddr = tl_q[IDX_W-1:0];
      link_wdata = slot_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      link_rd_q <= link_mem[rd_ptr[IDX_W-1:0]];
      data_rd_q <= data_mem[rd_ptr[IDX_W-1:0]];
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (enq_ok) begin
      data_mem[slot_q[IDX_W-1:0]] <= val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= in_cmd;
      qidx_q <= in_qidx;
      val_q  <= s_axis_tdata[QID_W +: VALUE_W];
      err_q  <= in_err;
      slot_q <= rd_ptr;
      tl_q   <= tail_q[in_qidx];
    end
  end

  // A queue's last slot keeps a stale link; an unlink of a queue's tail is
  // decided by comparing against the tail pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      free_head_q <= '0;
      link_vld_q  <= '0;
      out_vld_q   <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= NONE_PTR;
        tail_q[i] <= NONE_PTR;
      end
    end else begin
      state_q <= state_d;
      if (link_we) begin
        link_vld_q[link_waddr] <= 1'b1;
      end
      if (enq_ok) begin
        free_head_q    <= link_val;
        tail_q[qidx_q] <= slot_q;
        if (tl_q == NONE_PTR) begin
          head_q[qidx_q] <= slot_q;
        end
      end
      if (deq_ok) begin
        free_head_q    <= slot_q;
        head_q[qidx_q] <= new_head;
        if (new_head == NONE_PTR) begin
          tail_q[qidx_q] <= NONE_PTR;
        end
      end
      if (exec_fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_rv_q <= deq_ok ? data_rd_q : '0;
      if (!err_q) begin
        out_st_q <= STATUS_OK;
      end else if (cmd_q == CMD_DEQ) begin
        out_st_q <= STATUS_EMPTY;
      end else begin
        out_st_q <= STATUS_FULL;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - VALUE_W - STAT_W){1'b0}}, out_st_q, out_rv_q};

  logic [NUM_QUEUES-1:0] head_none_v;
  logic [NUM_QUEUES-1:0] tail_none_v;

  always_comb begin
    for (int i = 0; i < NUM_QUEUES; i++) begin
      head_none_v[i] = (head_q[i] == NONE_PTR);
      tail_none_v[i] = (tail_q[i] == NONE_PTR);
    end
  end

  a_head_tail_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_none_v == tail_none_v)
    else $error("Queue head and tail disagree on emptiness.");

  a_exec_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> m_axis_tvalid)
    else $error("Executed item produced no result beat.");

  a_stall_holds_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) && !exec_fire |=> (state_q == ST_EXEC) && !s_axis_tready)
    else $error("Stalled item left the execute step.");

  a_enq_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq_ok |-> (slot_q != NONE_PTR) && (slot_q == free_head_q))
    else $error("Enqueue executed without a free slot.");

endmodule
